@@ sv/jitp_pkg.sv @@
package jitp_pkg;

    localparam int VALUE_WIDTH_DEF = 64;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QUEUE_AW        = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] KIND_UDEC = 3'd0;
    localparam logic [2:0] KIND_HEX  = 3'd1;
    localparam logic [2:0] KIND_S8   = 3'd2;
    localparam logic [2:0] KIND_S32  = 3'd3;
    localparam logic [2:0] KIND_S64  = 3'd4;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF_A  = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF_A  = 8'h46;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;

    typedef enum logic [2:0] {
        CLS_WS,
        CLS_MINUS,
        CLS_QUOTE,
        CLS_ZERO,
        CLS_DIGIT,
        CLS_HEXALPHA,
        CLS_X,
        CLS_OTHER
    } t_cls;

    typedef struct packed {
        t_cls       cls;
        logic [3:0] nib;
        logic       last;
    } t_req;

    typedef enum logic [3:0] {
        PH_WS,
        PH_SIGN,
        PH_ZERO,
        PH_DIG,
        PH_HQ,
        PH_H0,
        PH_HX,
        PH_HDIG,
        PH_HEND,
        PH_ERR
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK,
        ST_NODIGITS,
        ST_LEADZERO,
        ST_BADCHAR,
        ST_RANGE
    } t_status;

    typedef struct packed {
        t_phase  phase;
        logic    minus;
        t_status err;
    } t_snap;

    function automatic logic kind_signed(input logic [2:0] kind);
        return (kind == KIND_S8) || (kind == KIND_S32) || (kind == KIND_S64);
    endfunction

    // largest decimal magnitude for the kind, capped at vw bits
    function automatic logic [63:0] dec_limit(input logic [2:0] kind, input logic minus,
                                              input int vw);
        int          w;
        logic [63:0] neg;
        if (!kind_signed(kind)) begin
            return {64{1'b1}} >> (64 - vw);
        end
        w = (kind == KIND_S8) ? 8 : ((kind == KIND_S32) ? 32 : 64);
        if (w > vw) begin
            w = vw;
        end
        neg = 64'd1 << (w - 1);
        return minus ? neg : (neg - 64'd1);
    endfunction

endpackage

@@ sv/jitp_front.sv @@
module jitp_front (
    input  logic              i_valid,
    input  logic [7:0]        i_char_byte,
    input  logic              i_token_end,
    input  logic              i_full,
    output logic              o_stall,
    output logic              o_push,
    output jitp_pkg::t_req    o_req
);

    jitp_pkg::t_cls cls;
    logic [3:0]     nib;

    always_comb begin
        cls = jitp_pkg::CLS_OTHER;
        nib = 4'd0;
        priority if (i_char_byte == jitp_pkg::CH_SPACE || i_char_byte == jitp_pkg::CH_TAB ||
                     i_char_byte == jitp_pkg::CH_LF || i_char_byte == jitp_pkg::CH_CR) begin
            cls = jitp_pkg::CLS_WS;
        end else if (i_char_byte == jitp_pkg::CH_MINUS) begin
            cls = jitp_pkg::CLS_MINUS;
        end else if (i_char_byte == jitp_pkg::CH_QUOTE) begin
            cls = jitp_pkg::CLS_QUOTE;
        end else if (i_char_byte == jitp_pkg::CH_ZERO) begin
            cls = jitp_pkg::CLS_ZERO;
        end else if (i_char_byte > jitp_pkg::CH_ZERO && i_char_byte <= jitp_pkg::CH_NINE) begin
            cls = jitp_pkg::CLS_DIGIT;
            nib = i_char_byte[3:0];
        end else if ((i_char_byte >= jitp_pkg::CH_LA && i_char_byte <= jitp_pkg::CH_LF_A) ||
                     (i_char_byte >= jitp_pkg::CH_UA && i_char_byte <= jitp_pkg::CH_UF_A)) begin
            cls = jitp_pkg::CLS_HEXALPHA;
            nib = 4'(i_char_byte[3:0] + 4'd9);
        end else if (i_char_byte == jitp_pkg::CH_LX || i_char_byte == jitp_pkg::CH_UX) begin
            cls = jitp_pkg::CLS_X;
        end else begin
            cls = jitp_pkg::CLS_OTHER;
        end
    end

    assign o_stall    = i_full;
    assign o_push     = i_valid && !i_full;
    assign o_req.cls  = cls;
    assign o_req.nib  = nib;
    assign o_req.last = i_token_end;

endmodule

@@ sv/jitp_queue.sv @@
module jitp_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  jitp_pkg::t_req    i_req,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output jitp_pkg::t_req    o_req
);

    localparam int D  = jitp_pkg::QUEUE_DEPTH;
    localparam int AW = jitp_pkg::QUEUE_AW;
    localparam int CW = jitp_pkg::QUEUE_CW;

    jitp_pkg::t_req r_mem [D];
    logic [AW-1:0]  r_wr_ptr;
    logic [AW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic [AW-1:0]  n_wr_ptr;
    logic [AW-1:0]  n_rd_ptr;

    assign n_wr_ptr = (r_wr_ptr == AW'(D - 1)) ? '0 : AW'(r_wr_ptr + 1'b1);
    assign n_rd_ptr = (r_rd_ptr == AW'(D - 1)) ? '0 : AW'(r_rd_ptr + 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= CW'(r_count + 1'b1);
            end else if (i_pop && !i_push) begin
                r_count <= CW'(r_count - 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_req;
        end
    end

    assign o_full  = (r_count == CW'(D));
    assign o_valid = (r_count != '0);
    assign o_req   = r_mem[r_rd_ptr];

endmodule

@@ sv/jitp_back.sv @@
module jitp_back #(
    parameter int VALUE_WIDTH = jitp_pkg::VALUE_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [2:0]              i_kind,
    input  logic                    i_valid,
    input  jitp_pkg::t_req          i_req,
    input  logic                    i_fin_ready,
    output logic                    o_pop,
    output logic                    o_fin_push,
    output jitp_pkg::t_snap         o_snap,
    output logic [VALUE_WIDTH-1:0]  o_acc
);

    localparam int W  = VALUE_WIDTH;
    localparam int PW = VALUE_WIDTH + 4;

    jitp_pkg::t_phase  r_phase;
    jitp_pkg::t_phase  n_phase;
    jitp_pkg::t_status r_err;
    jitp_pkg::t_status n_err;
    logic              r_minus;
    logic              n_minus;
    logic [W-1:0]      r_acc;
    logic [W-1:0]      n_acc;

    logic [63:0]       lim64;
    logic [W-1:0]      lim_dec;
    logic [PW-1:0]     prod_dec;
    logic [PW-1:0]     prod_hex;
    logic              ovf_dec;
    logic              ovf_hex;
    logic              is_dec;
    logic              is_hex;
    logic              take_dec;
    logic              take_hex;
    logic              set_minus;
    logic              do_fail;
    jitp_pkg::t_status fail_code;

    assign lim64    = jitp_pkg::dec_limit(i_kind, r_minus, W);
    assign lim_dec  = lim64[W-1:0];
    assign prod_dec = PW'({r_acc, 3'b000}) + PW'({r_acc, 1'b0}) + PW'(i_req.nib);
    assign prod_hex = {r_acc, 4'b0000} + PW'(i_req.nib);
    assign ovf_dec  = prod_dec > PW'(lim_dec);
    assign ovf_hex  = prod_hex[PW-1:W] != '0;

    assign is_dec = (i_req.cls == jitp_pkg::CLS_ZERO) || (i_req.cls == jitp_pkg::CLS_DIGIT);
    assign is_hex = is_dec || (i_req.cls == jitp_pkg::CLS_HEXALPHA);

    assign o_pop = i_valid && (!i_req.last || i_fin_ready);

    // next phase and error latch
    always_comb begin
        n_phase   = r_phase;
        n_err     = r_err;
        take_dec  = 1'b0;
        take_hex  = 1'b0;
        set_minus = 1'b0;
        do_fail   = 1'b0;
        fail_code = jitp_pkg::ST_BADCHAR;
        unique case (r_phase)
            jitp_pkg::PH_WS: begin
                unique case (i_req.cls)
                    jitp_pkg::CLS_WS: begin
                    end
                    jitp_pkg::CLS_MINUS: begin
                        if (jitp_pkg::kind_signed(i_kind)) begin
                            set_minus = 1'b1;
                            n_phase   = jitp_pkg::PH_SIGN;
                        end else begin
                            do_fail = 1'b1;
                        end
                    end
                    jitp_pkg::CLS_QUOTE: begin
                        if (i_kind == jitp_pkg::KIND_HEX) begin
                            n_phase = jitp_pkg::PH_HQ;
                        end else begin
                            do_fail = 1'b1;
                        end
                    end
                    jitp_pkg::CLS_ZERO: begin
                        n_phase = jitp_pkg::PH_ZERO;
                    end
                    jitp_pkg::CLS_DIGIT: begin
                        if (ovf_dec) begin
                            do_fail   = 1'b1;
                            fail_code = jitp_pkg::ST_RANGE;
                        end else begin
                            take_dec = 1'b1;
                            n_phase  = jitp_pkg::PH_DIG;
                        end
                    end
                    default: begin
                        do_fail = 1'b1;
                    end
                endcase
            end
            jitp_pkg::PH_SIGN: begin
                if (i_req.cls == jitp_pkg::CLS_ZERO) begin
                    n_phase = jitp_pkg::PH_ZERO;
                end else if (i_req.cls == jitp_pkg::CLS_DIGIT) begin
                    if (ovf_dec) begin
                        do_fail   = 1'b1;
                        fail_code = jitp_pkg::ST_RANGE;
                    end else begin
                        take_dec = 1'b1;
                        n_phase  = jitp_pkg::PH_DIG;
                    end
                end else begin
                    do_fail = 1'b1;
                end
            end
            jitp_pkg::PH_ZERO: begin
                do_fail   = 1'b1;
                fail_code = is_dec ? jitp_pkg::ST_LEADZERO : jitp_pkg::ST_BADCHAR;
            end
            jitp_pkg::PH_DIG: begin
                if (is_dec) begin
                    if (ovf_dec) begin
                        do_fail   = 1'b1;
                        fail_code = jitp_pkg::ST_RANGE;
                    end else begin
                        take_dec = 1'b1;
                    end
                end else begin
                    do_fail = 1'b1;
                end
            end
            jitp_pkg::PH_HQ: begin
                if (i_req.cls == jitp_pkg::CLS_ZERO) begin
                    n_phase = jitp_pkg::PH_H0;
                end else begin
                    do_fail   = 1'b1;
                    fail_code = (i_req.cls == jitp_pkg::CLS_QUOTE) ?
                                jitp_pkg::ST_NODIGITS : jitp_pkg::ST_BADCHAR;
                end
            end
            jitp_pkg::PH_H0: begin
                if (i_req.cls == jitp_pkg::CLS_X) begin
                    n_phase = jitp_pkg::PH_HX;
                end else begin
                    do_fail   = 1'b1;
                    fail_code = (i_req.cls == jitp_pkg::CLS_QUOTE) ?
                                jitp_pkg::ST_NODIGITS : jitp_pkg::ST_BADCHAR;
                end
            end
            jitp_pkg::PH_HX, jitp_pkg::PH_HDIG: begin
                if (is_hex) begin
                    if (ovf_hex) begin
                        do_fail   = 1'b1;
                        fail_code = jitp_pkg::ST_RANGE;
                    end else begin
                        take_hex = 1'b1;
                        n_phase  = jitp_pkg::PH_HDIG;
                    end
                end else if (i_req.cls == jitp_pkg::CLS_QUOTE) begin
                    if (r_phase == jitp_pkg::PH_HDIG) begin
                        n_phase = jitp_pkg::PH_HEND;
                    end else begin
                        do_fail   = 1'b1;
                        fail_code = jitp_pkg::ST_NODIGITS;
                    end
                end else begin
                    do_fail = 1'b1;
                end
            end
            jitp_pkg::PH_HEND: begin
                do_fail = 1'b1;
            end
            default: begin
            end
        endcase
        if (do_fail) begin
            n_phase = jitp_pkg::PH_ERR;
            if (r_err == jitp_pkg::ST_OK) begin
                n_err = fail_code;
            end
        end
    end

    // accumulator and sign
    always_comb begin
        priority if (take_dec) begin
            n_acc = prod_dec[W-1:0];
        end else if (take_hex) begin
            n_acc = prod_hex[W-1:0];
        end else begin
            n_acc = r_acc;
        end
        n_minus = r_minus | set_minus;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= jitp_pkg::PH_WS;
            r_err   <= jitp_pkg::ST_OK;
            r_minus <= 1'b0;
            r_acc   <= '0;
        end else if (o_pop) begin
            if (i_req.last) begin
                r_phase <= jitp_pkg::PH_WS;
                r_err   <= jitp_pkg::ST_OK;
                r_minus <= 1'b0;
                r_acc   <= '0;
            end else begin
                r_phase <= n_phase;
                r_err   <= n_err;
                r_minus <= n_minus;
                r_acc   <= n_acc;
            end
        end
    end

    assign o_fin_push   = o_pop && i_req.last;
    assign o_snap.phase = n_phase;
    assign o_snap.minus = n_minus;
    assign o_snap.err   = n_err;
    assign o_acc        = n_acc;

endmodule

@@ sv/jitp_finish.sv @@
module jitp_finish #(
    parameter int VALUE_WIDTH = jitp_pkg::VALUE_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [2:0]              i_kind,
    input  logic                    i_push,
    input  jitp_pkg::t_snap         i_snap,
    input  logic [VALUE_WIDTH-1:0]  i_acc,
    input  logic                    i_out_stall,
    output logic                    o_fin_ready,
    output logic                    o_out_valid,
    output logic [VALUE_WIDTH-1:0]  o_value_bits,
    output logic [2:0]              o_status_code
);

    localparam int W = VALUE_WIDTH;

    logic              r_fin_valid;
    jitp_pkg::t_snap   r_snap;
    logic [W-1:0]      r_acc;
    logic              r_out_valid;
    logic [W-1:0]      r_value;
    jitp_pkg::t_status r_status;

    logic              out_ready;
    logic [63:0]       lim64;
    logic [W-1:0]      lim;
    logic [W-1:0]      n_value;
    jitp_pkg::t_status n_status;

    assign out_ready   = !r_out_valid || !i_out_stall;
    assign o_fin_ready = !r_fin_valid || out_ready;
    assign lim64       = jitp_pkg::dec_limit(i_kind, r_snap.minus, W);
    assign lim         = lim64[W-1:0];

    always_comb begin
        n_value  = '0;
        n_status = jitp_pkg::ST_BADCHAR;
        unique case (r_snap.phase)
            jitp_pkg::PH_WS, jitp_pkg::PH_SIGN: begin
                n_status = jitp_pkg::ST_NODIGITS;
            end
            jitp_pkg::PH_ZERO, jitp_pkg::PH_DIG: begin
                if (r_snap.minus && !jitp_pkg::kind_signed(i_kind)) begin
                    n_status = jitp_pkg::ST_BADCHAR;
                end else if (r_acc > lim) begin
                    n_status = jitp_pkg::ST_RANGE;
                end else begin
                    n_status = jitp_pkg::ST_OK;
                    n_value  = r_snap.minus ? W'(-r_acc) : r_acc;
                end
            end
            jitp_pkg::PH_HEND: begin
                n_status = jitp_pkg::ST_OK;
                n_value  = r_acc;
            end
            jitp_pkg::PH_ERR: begin
                n_status = r_snap.err;
            end
            default: begin
                n_status = jitp_pkg::ST_BADCHAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_fin_ready) begin
                r_fin_valid <= i_push;
            end
            if (out_ready) begin
                r_out_valid <= r_fin_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_fin_ready && i_push) begin
            r_snap <= i_snap;
            r_acc  <= i_acc;
        end
        if (out_ready && r_fin_valid) begin
            r_value  <= n_value;
            r_status <= n_status;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_value_bits  = r_value;
    assign o_status_code = r_status;

endmodule

@@ sv/json_integer_token_parser.sv @@
// Channel   Valid          Stall          Payload
// input     i_in_valid     o_in_stall     i_char_byte, i_token_end
// output    o_out_valid    i_out_stall    o_value_bits, o_status_code
// config    i_cfg_we       -              i_cfg_data (number_kind)
//
// One byte per cycle while o_in_stall is low. The result of a token passes
// the queue, the digit step (multiply by 10 or 16 and add), then the range
// check and sign in the finish stage.
// Synchronous active-low reset empties the queue, clears the token state
// and sets number_kind to 0. A four-entry request queue absorbs output stalls;
// o_in_stall rises only when it is full.
module json_integer_token_parser #(
    parameter int VALUE_WIDTH = jitp_pkg::VALUE_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [2:0]              i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [7:0]              i_char_byte,
    input  logic                    i_token_end,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [VALUE_WIDTH-1:0]  o_value_bits,
    output logic [2:0]              o_status_code
);

    logic [2:0]              r_kind;
    logic                    full;
    logic                    push;
    jitp_pkg::t_req          req_in;
    logic                    q_valid;
    jitp_pkg::t_req          q_req;
    logic                    pop;
    logic                    fin_ready;
    logic                    fin_push;
    jitp_pkg::t_snap         snap;
    logic [VALUE_WIDTH-1:0]  acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= jitp_pkg::KIND_UDEC;
        end else if (i_cfg_we) begin
            r_kind <= i_cfg_data;
        end
    end

    jitp_front u_front (
        .i_valid     (i_in_valid),
        .i_char_byte (i_char_byte),
        .i_token_end (i_token_end),
        .i_full      (full),
        .o_stall     (o_in_stall),
        .o_push      (push),
        .o_req       (req_in)
    );

    jitp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (req_in),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_req   (q_req)
    );

    jitp_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_kind      (r_kind),
        .i_valid     (q_valid),
        .i_req       (q_req),
        .i_fin_ready (fin_ready),
        .o_pop       (pop),
        .o_fin_push  (fin_push),
        .o_snap      (snap),
        .o_acc       (acc)
    );

    jitp_finish #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_finish (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_kind        (r_kind),
        .i_push        (fin_push),
        .i_snap        (snap),
        .i_acc         (acc),
        .i_out_stall   (i_out_stall),
        .o_fin_ready   (fin_ready),
        .o_out_valid   (o_out_valid),
        .o_value_bits  (o_value_bits),
        .o_status_code (o_status_code)
    );

endmodule
